// ===== design/int32_to_decimal_ascii_unit_assert.svh =====
// Assertion macros shared by the checker of the decimal text unit.
`ifndef INT32_TO_DECIMAL_ASCII_UNIT_ASSERT_SVH
`define INT32_TO_DECIMAL_ASCII_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

// ===== design/int32da_pkg.sv =====
// Types and constants of the decimal text unit.
`default_nettype none
package int32da_pkg;

  localparam int unsigned NUM_DIGITS = 10;
  localparam int unsigned CNT_W      = $clog2(NUM_DIGITS);

  localparam logic [6:0]  CH_MINUS = 7'd45;
  localparam logic [6:0]  CH_ZERO  = 7'd48;

  // ceil(2^35 / 10): x * RECIP10 >> 35 is x / 10 for every 32-bit x
  localparam logic [31:0] RECIP10  = 32'hCCCC_CCCD;
  localparam int unsigned RECIP_SH = 35;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_DIV  = 3'b010,
    ST_EMIT = 3'b100
  } state_e;

  typedef struct packed {
    logic [31:0] quo;
    logic [3:0]  rem;
  } div_res_t;

endpackage
`default_nettype wire

// ===== design/int32da_if.sv =====
// Handshake channels of the decimal text unit: value in, characters out.
`default_nettype none
interface int32da_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

interface int32da_out_if;
  logic       valid;
  logic       ready;
  logic [6:0] char_code;
  logic       last;

  modport source (output valid, output char_code, output last, input ready);
  modport sink   (input valid, input char_code, input last, output ready);
endinterface
`default_nettype wire

// ===== design/int32_to_decimal_ascii_unit.sv =====
// First character registered in EMIT after all D digits are stored (D = digit count, 1..10).
// A new value is taken in IDLE once all N characters (D..11) are loaded; the pace is
//   set by the single divide-by-ten unit (one digit a cycle) and the one-character output.
// Output register lets the final character wait while the next value is taken.
// Reset: rst_ni asynchronous active low; sequencer idles, output valid cleared.
// Digit store and payload registers are not reset.
`default_nettype none
module int32_to_decimal_ascii_unit (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  int32da_in_if.sink           in_i,
  int32da_out_if.source        out_o
);

  localparam int unsigned CW = int32da_pkg::CNT_W;

  // Sequencer
  int32da_pkg::state_e   state_q, state_d;
  logic                  neg_q, neg_d;      // sign still to be sent
  logic [31:0]           mag_q, mag_d;      // remaining magnitude
  logic [CW-1:0]         cnt_q, cnt_d;      // write index in DIV, read index in EMIT

  // Digits stored least significant first, read back in reverse
  logic [3:0]            digit_q [int32da_pkg::NUM_DIGITS];

  // Output register
  logic                  ovalid_q, ovalid_d;
  logic [6:0]            ochar_q, ochar_d;
  logic                  olast_q, olast_d;

  int32da_pkg::div_res_t div_res;
  logic                  in_txn;
  logic                  slot_free;
  logic                  load;

  int32da_div10 u_div10 (
    .mag_i (mag_q),
    .res_o (div_res)
  );

  assign in_i.ready = (state_q == int32da_pkg::ST_IDLE);
  assign in_txn     = in_i.valid && in_i.ready;
  assign slot_free  = !ovalid_q || out_o.ready;
  assign load       = (state_q == int32da_pkg::ST_EMIT) && slot_free;

  always_comb begin
    state_d  = state_q;
    neg_d    = neg_q;
    mag_d    = mag_q;
    cnt_d    = cnt_q;
    ovalid_d = ovalid_q && !out_o.ready;
    ochar_d  = ochar_q;
    olast_d  = olast_q;
    case (state_q)
      int32da_pkg::ST_IDLE: begin
        if (in_txn) begin
          // two's complement magnitude; the most negative value maps to 2^31
          neg_d   = in_i.value[31];
          mag_d   = in_i.value[31] ? (32'd0 - in_i.value) : in_i.value;
          cnt_d   = '0;
          state_d = int32da_pkg::ST_DIV;
        end
      end
      int32da_pkg::ST_DIV: begin
        mag_d = div_res.quo;
        // cnt stays on the top digit when the quotient runs out
        if (div_res.quo == 32'd0) begin
          state_d = int32da_pkg::ST_EMIT;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      int32da_pkg::ST_EMIT: begin
        if (load) begin
          ovalid_d = 1'b1;
          if (neg_q) begin
            ochar_d = int32da_pkg::CH_MINUS;
            olast_d = 1'b0;
            neg_d   = 1'b0;
          end else begin
            ochar_d = int32da_pkg::CH_ZERO + {3'd0, digit_q[cnt_q]};
            olast_d = (cnt_q == '0);
            if (cnt_q == '0) begin
              state_d = int32da_pkg::ST_IDLE;
            end else begin
              cnt_d = cnt_q - 1'b1;
            end
          end
        end
      end
      default: begin
        state_d = int32da_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= int32da_pkg::ST_IDLE;
      neg_q    <= 1'b0;
      cnt_q    <= '0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      neg_q    <= neg_d;
      cnt_q    <= cnt_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q   <= mag_d;
    ochar_q <= ochar_d;
    olast_q <= olast_d;
    if (state_q == int32da_pkg::ST_DIV) begin
      digit_q[cnt_q] <= div_res.rem;
    end
  end

  assign out_o.valid     = ovalid_q;
  assign out_o.char_code = ochar_q;
  assign out_o.last      = olast_q;

endmodule
`default_nettype wire

// ===== design/int32da_div10.sv =====
// Shared divide-by-ten unit: reciprocal multiply, remainder by shift-add.
`default_nettype none
module int32da_div10 (
  input  logic [31:0]            mag_i,
  output int32da_pkg::div_res_t  res_o
);

  logic [63:0] prod;
  logic [31:0] quo;
  logic [31:0] quo_x10;
  logic [31:0] diff;

  assign prod    = {32'd0, mag_i} * {32'd0, int32da_pkg::RECIP10};
  assign quo     = {3'd0, prod[63:int32da_pkg::RECIP_SH]};
  assign quo_x10 = {quo[28:0], 3'd0} + {quo[30:0], 1'b0};
  assign diff    = mag_i - quo_x10;

  assign res_o.quo = quo;
  assign res_o.rem = diff[3:0];

endmodule
`default_nettype wire

// ===== design/int32da_checker.sv =====
// Port-level checker of the decimal text unit and its bind.
`default_nettype none
`include "int32_to_decimal_ascii_unit_assert.svh"
module int32da_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_i,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [6:0] out_char_i,
  input logic       out_last_i
);

  logic is_minus;
  logic is_digit;
  logic out_stall;

  assign is_minus  = (out_char_i == int32da_pkg::CH_MINUS);
  assign is_digit  = (out_char_i >= int32da_pkg::CH_ZERO) &&
                     (out_char_i <= int32da_pkg::CH_ZERO + 7'd9);
  assign out_stall = out_valid_i && !out_ready_i;

  `ASSERT_IMPLIES(a_char_legal, clk_i, rst_ni, out_valid_i, is_minus || is_digit)
  `ASSERT_IMPLIES(a_minus_not_last, clk_i, rst_ni, out_valid_i && is_minus, !out_last_i)
  `ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, in_valid_i && in_ready_i, !in_ready_i)
  `ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_stall, out_valid_i && $stable({out_char_i, out_last_i}))

endmodule

bind int32_to_decimal_ascii_unit int32da_checker u_int32da_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_char_i  (out_o.char_code),
  .out_last_i  (out_o.last)
);
`default_nettype wire
